### hw/rtl/assert_macros.svh
// Assertion helpers used by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked at every rising clock edge outside reset.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication checked at every rising clock edge outside reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

### hw/rtl/bsc_pkg.sv
package bsc_pkg;

    typedef struct packed {
        logic        mode;
        logic [23:0] raw_value;
    } bsc_in_t;

    typedef struct packed {
        logic               result_kind;
        logic signed [31:0] result_value;
        logic               fault;
    } bsc_out_t;

    localparam int CFG_WIDTH = 48;
    localparam int CFG_INDEX_WIDTH = 3;

    localparam logic [2:0] REG_ABC  = 3'd0;
    localparam logic [2:0] REG_456  = 3'd1;
    localparam logic [2:0] REG_B12  = 3'd2;
    localparam logic [2:0] REG_MCMD = 3'd3;
    localparam logic [2:0] REG_OSS  = 3'd4;

    // Sequencer steps: each uses the multiplier at most once, or runs the divider.
    typedef enum logic [5:0] {
        S_IDLE,
        S_T1, S_T2, S_T3, S_TDIV, S_T4,
        S_P1, S_P2, S_P3, S_P4, S_P5, S_P6, S_P7, S_P8, S_P9,
        S_P10, S_PDIV, S_P11, S_P12, S_P13, S_P14, S_P15,
        S_OUT
    } bsc_state_t;

    // Divider request: unsigned 32 by 32.
    typedef struct packed {
        logic        start;
        logic [31:0] num;
        logic [31:0] den;
    } bsc_div_req_t;

    typedef struct packed {
        logic        done;
        logic [31:0] quot;
    } bsc_div_rsp_t;

    function automatic logic [31:0] sx16(input logic [15:0] v);
        return {{16{v[15]}}, v};
    endfunction

endpackage

### hw/rtl/bsc_divider.sv
module bsc_divider (
    input  logic                  clk,
    input  logic                  rst_n,
    input  bsc_pkg::bsc_div_req_t req,
    output bsc_pkg::bsc_div_rsp_t rsp
);
    import bsc_pkg::*;

    logic [31:0] quot_reg, quot_next;
    logic [31:0] rem_reg, rem_next;
    logic [31:0] den_reg, den_next;
    logic [5:0]  cnt_reg, cnt_next;
    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    logic [32:0] trial;

    always_comb
    begin
        quot_next = quot_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        trial     = {rem_reg, quot_reg[31]} - {1'b0, den_reg};
        if (req.start)
        begin
            quot_next = req.num;
            rem_next  = '0;
            den_next  = req.den;
            cnt_next  = 6'd32;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            // restoring step: one quotient bit per cycle
            if (!trial[32])
                rem_next = trial[31:0];
            else
                rem_next = {rem_reg[30:0], quot_reg[31]};
            quot_next = {quot_reg[30:0], ~trial[32]};
            cnt_next  = cnt_reg - 6'd1;
            if (cnt_reg == 6'd1)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quot_reg <= quot_next;
        rem_reg  <= rem_next;
        den_reg  <= den_next;
    end

    assign rsp.done = done_reg;
    assign rsp.quot = quot_reg;

endmodule

### hw/rtl/barometric_sensor_compensation.sv
// Barometric sensor compensation. Accepts one request at a time: a raw temperature
// (mode 0) or raw pressure (mode 1) reading, and returns one compensated result.
// Timing is set by the single shared 32x32 multiplier, used at most once per step,
// and by the bit-serial divider, whose wait state lasts until the division is done.
// A zero divisor cuts the run short. The block returns to idle after the result
// is taken and only then accepts the next request; output stall adds to the run,
// and the input stays stalled from acceptance until the result is taken. A
// temperature request with a nonzero divisor stores B5 for later pressure requests.
// A zero divisor sets fault with value 0.
// Calibration must be written by the user through the plain write port while the
// block is idle; the block itself does not enforce this.
module barometric_sensor_compensation (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  bsc_pkg::bsc_in_t                    in_data,
    output logic                                out_valid,
    input  logic                                out_stall,
    output bsc_pkg::bsc_out_t                   out_data,
    input  logic                                cfg_we,
    input  logic [bsc_pkg::CFG_INDEX_WIDTH-1:0] cfg_index,
    input  logic [bsc_pkg::CFG_WIDTH-1:0]       cfg_data
);
    import bsc_pkg::*;
    `include "assert_macros.svh"

    logic [47:0] abc_reg, c456_reg;
    logic [31:0] b12_reg, mcmd_reg;
    logic [1:0]  oss_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            abc_reg  <= '0;
            c456_reg <= '0;
            b12_reg  <= '0;
            mcmd_reg <= '0;
            oss_reg  <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_ABC:  abc_reg  <= cfg_data;
                REG_456:  c456_reg <= cfg_data;
                REG_B12:  b12_reg  <= cfg_data[31:0];
                REG_MCMD: mcmd_reg <= cfg_data[31:0];
                REG_OSS:  oss_reg  <= cfg_data[1:0];
                default:  ;
            endcase
        end
    end

    logic [31:0] ac1, ac2, ac3, ac4, ac5, ac6, b1, b2, mc, md;
    assign ac1 = sx16(abc_reg[47:32]);
    assign ac2 = sx16(abc_reg[31:16]);
    assign ac3 = sx16(abc_reg[15:0]);
    assign ac4 = {16'd0, c456_reg[47:32]};
    assign ac5 = {16'd0, c456_reg[31:16]};
    assign ac6 = {16'd0, c456_reg[15:0]};
    assign b1  = sx16(b12_reg[31:16]);
    assign b2  = sx16(b12_reg[15:0]);
    assign mc  = sx16(mcmd_reg[31:16]);
    assign md  = sx16(mcmd_reg[15:0]);

    bsc_state_t  state_reg, state_next;
    logic [31:0] b5_reg, b5_next;
    logic        mode_reg, mode_next;
    logic [23:0] raw_reg, raw_next;
    logic [31:0] a_reg, a_next;   // scratch registers
    logic [31:0] b_reg, b_next;
    logic [31:0] c_reg, c_next;
    logic [31:0] d_reg, d_next;
    logic [31:0] e_reg, e_next;
    logic        neg_reg, neg_next;
    logic        fault_reg, fault_next;
    logic [31:0] val_reg, val_next;

    // shared multiplier, low 32 bits of the product
    logic [31:0] mul_a, mul_b, prod;
    logic [63:0] prod_full;
    assign prod_full = {32'd0, mul_a} * {32'd0, mul_b};
    assign prod = prod_full[31:0];

    // arithmetic right shift
    function automatic logic [31:0] asr(input logic [31:0] x, input logic [4:0] n);
        return 32'($signed(x) >>> n);
    endfunction

    bsc_div_req_t div_req;
    bsc_div_rsp_t div_rsp;
    bsc_divider u_div (.clk(clk), .rst_n(rst_n), .req(div_req), .rsp(div_rsp));

    logic [31:0] tmp, num, den_abs, qs;

    always_comb
    begin
        state_next = state_reg;
        b5_next    = b5_reg;
        mode_next  = mode_reg;
        raw_next   = raw_reg;
        a_next     = a_reg;
        b_next     = b_reg;
        c_next     = c_reg;
        d_next     = d_reg;
        e_next     = e_reg;
        neg_next   = neg_reg;
        fault_next = fault_reg;
        val_next   = val_reg;
        mul_a      = '0;
        mul_b      = '0;
        div_req    = '0;
        tmp        = '0;
        num        = '0;
        den_abs    = '0;
        qs         = div_rsp.quot;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    mode_next  = in_data.mode;
                    raw_next   = in_data.raw_value;
                    fault_next = 1'b0;
                    val_next   = '0;
                    state_next = in_data.mode ? S_P1 : S_T1;
                end
            end
            // temperature
            S_T1:
            begin
                mul_a = {16'd0, raw_reg[15:0]} - ac6;
                mul_b = ac5;
                a_next = asr(prod, 5'd15);           // X1
                state_next = S_T2;
            end
            S_T2:
            begin
                tmp = a_reg + md;
                b_next = tmp;
                if (tmp == '0)
                begin
                    fault_next = 1'b1;
                    state_next = S_OUT;
                end
                else
                    state_next = S_T3;
            end
            S_T3:
            begin
                num = mc << 11;
                den_abs = b_reg[31] ? -b_reg : b_reg;
                neg_next = num[31] ^ b_reg[31];
                div_req.start = 1'b1;
                div_req.num = num[31] ? -num : num;
                div_req.den = den_abs;
                state_next = S_TDIV;
            end
            S_TDIV:
            begin
                if (div_rsp.done)
                begin
                    qs = neg_reg ? -div_rsp.quot : div_rsp.quot;
                    b5_next = a_reg + qs;
                    state_next = S_T4;
                end
            end
            S_T4:
            begin
                val_next = asr(b5_reg + 32'd8, 5'd4);
                state_next = S_OUT;
            end
            // pressure
            S_P1:
            begin
                a_next = b5_reg - 32'd4000;          // B6
                state_next = S_P2;
            end
            S_P2:
            begin
                mul_a = a_reg; mul_b = a_reg;
                b_next = asr(prod, 5'd12);           // sq
                state_next = S_P3;
            end
            S_P3:
            begin
                mul_a = b2; mul_b = b_reg;
                c_next = asr(prod, 5'd11);           // X1
                state_next = S_P4;
            end
            S_P4:
            begin
                mul_a = ac2; mul_b = a_reg;
                c_next = c_reg + asr(prod, 5'd11);   // X3
                state_next = S_P5;
            end
            S_P5:
            begin
                tmp = (((ac1 << 2) + c_reg) << oss_reg) + 32'd2;
                // divide by 4 toward zero
                d_next = asr(tmp + (tmp[31] ? 32'd3 : 32'd0), 5'd2);  // B3
                state_next = S_P6;
            end
            S_P6:
            begin
                mul_a = ac3; mul_b = a_reg;
                c_next = asr(prod, 5'd13);
                state_next = S_P7;
            end
            S_P7:
            begin
                mul_a = b1; mul_b = b_reg;
                c_next = asr(c_reg + asr(prod, 5'd16) + 32'd2, 5'd2);  // X3
                state_next = S_P8;
            end
            S_P8:
            begin
                mul_a = ac4; mul_b = c_reg + 32'd32768;
                e_next = prod >> 15;                 // B4
                state_next = S_P9;
            end
            S_P9:
            begin
                mul_a = ({8'd0, raw_reg} >> (4'd8 - {2'd0, oss_reg})) - d_reg;
                mul_b = 32'd50000 >> oss_reg;
                c_next = prod;                       // B7
                state_next = S_P10;
            end
            S_P10:
            begin
                if (e_reg == '0)
                begin
                    fault_next = 1'b1;
                    state_next = S_OUT;
                end
                else
                begin
                    neg_next = c_reg[31];
                    div_req.start = 1'b1;
                    div_req.num = c_reg[31] ? c_reg : (c_reg << 1);
                    div_req.den = e_reg;
                    state_next = S_PDIV;
                end
            end
            S_PDIV:
            begin
                if (div_rsp.done)
                begin
                    a_next = neg_reg ? (div_rsp.quot << 1) : div_rsp.quot;  // p
                    state_next = S_P11;
                end
            end
            S_P11:
            begin
                mul_a = asr(a_reg, 5'd8); mul_b = asr(a_reg, 5'd8);
                b_next = prod;
                state_next = S_P12;
            end
            S_P12:
            begin
                mul_a = b_reg; mul_b = 32'd3038;
                b_next = asr(prod, 5'd16);
                state_next = S_P13;
            end
            S_P13:
            begin
                mul_a = 32'd0 - 32'd7357; mul_b = a_reg;
                c_next = asr(prod, 5'd16);
                state_next = S_P14;
            end
            S_P14:
            begin
                val_next = a_reg + asr(b_reg + c_reg + 32'd3791, 5'd4);
                state_next = S_OUT;
            end
            S_OUT:
            begin
                if (!out_stall)
                    state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            b5_reg    <= '0;
        end
        else
        begin
            state_reg <= state_next;
            b5_reg    <= b5_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mode_reg  <= mode_next;
        raw_reg   <= raw_next;
        a_reg     <= a_next;
        b_reg     <= b_next;
        c_reg     <= c_next;
        d_reg     <= d_next;
        e_reg     <= e_next;
        neg_reg   <= neg_next;
        fault_reg <= fault_next;
        val_reg   <= val_next;
    end

    // accept only when idle; hold the result until taken
    assign in_stall  = (state_reg != S_IDLE);
    assign out_valid = (state_reg == S_OUT);
    assign out_data.result_kind  = mode_reg;
    assign out_data.result_value = $signed(val_reg);
    assign out_data.fault        = fault_reg;

    `ASSERT_IMPL(a_excl, clk, rst_n, out_valid, in_stall)
    `ASSERT_IMPL(a_fault_zero, clk, rst_n, out_valid && out_data.fault,
        out_data.result_value == 0)
    `ASSERT_NEXT(a_hold, clk, rst_n, out_valid && out_stall, out_valid && $stable(out_data))

endmodule

### sim/barometric_sensor_compensation_tb.sv
`timescale 1ns / 1ps

module barometric_sensor_compensation_tb;

    import bsc_pkg::*;

    localparam int RAND_REQUESTS = 1650;
    localparam int DRAIN_CYCLES  = 120;

    // One directed row: configuration to apply first (when cfg_set), the request,
    // and an optional hand-typed expectation checked on top of the predictor.
    typedef struct {
        logic        cfg_set;
        logic [47:0] abc;
        logic [47:0] c456;
        logic [31:0] b12;
        logic [31:0] mcmd;
        logic [1:0]  oss;
        logic        mode;
        logic [23:0] raw;
        logic        known;
        logic [31:0] known_value;
        logic        known_fault;
    } stim_row_t;

    logic       clk;
    logic       rst_n;
    logic       in_valid;
    logic       in_stall;
    bsc_in_t    in_data;
    logic       out_valid;
    logic       out_stall;
    bsc_out_t   out_data;
    logic       cfg_we;
    logic [CFG_INDEX_WIDTH-1:0] cfg_index;
    logic [CFG_WIDTH-1:0]       cfg_data;

    // Predictor copy of the calibration and of the stored B5.
    logic [47:0] cal_abc;
    logic [47:0] cal_456;
    logic [31:0] cal_b12;
    logic [31:0] cal_mcmd;
    logic [1:0]  cal_oss;
    logic [31:0] stored_b5;

    bsc_out_t    compensated_q[$];
    int          fail_count;
    logic        steady;       // no idling while set

    barometric_sensor_compensation uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    function automatic logic [31:0] asr32(input logic [31:0] x, input int n);
        return $unsigned($signed(x) >>> n);
    endfunction

    function automatic logic [31:0] ext16(input logic [15:0] v);
        return {{16{v[15]}}, v};
    endfunction

    // Signed division truncating toward zero.
    function automatic logic [31:0] div_trunc(input logic [31:0] a, input logic [31:0] b);
        logic [31:0] ma;
        logic [31:0] mb;
        logic [31:0] q;
        ma = a[31] ? -a : a;
        mb = b[31] ? -b : b;
        q = ma / mb;
        return (a[31] != b[31]) ? -q : q;
    endfunction

    // Compensate one request; a temperature request with a nonzero divisor updates the stored B5.
    function automatic bsc_out_t compensate(input bsc_in_t req);
        bsc_out_t r;
        logic [31:0] ac1, ac2, ac3, ac4, ac5, ac6, b1, b2, mc, md;
        logic [31:0] ut, x1, x2, x3, den, b5, up, b6, sq, b3, b4, b7, p;
        ac1 = ext16(cal_abc[47:32]);
        ac2 = ext16(cal_abc[31:16]);
        ac3 = ext16(cal_abc[15:0]);
        ac4 = {16'd0, cal_456[47:32]};
        ac5 = {16'd0, cal_456[31:16]};
        ac6 = {16'd0, cal_456[15:0]};
        b1 = ext16(cal_b12[31:16]);
        b2 = ext16(cal_b12[15:0]);
        mc = ext16(cal_mcmd[31:16]);
        md = ext16(cal_mcmd[15:0]);
        r.result_kind = req.mode;
        r.result_value = '0;
        r.fault = 1'b0;
        if (!req.mode)
        begin
            ut = {16'd0, req.raw_value[15:0]};
            x1 = asr32((ut - ac6) * ac5, 15);
            den = x1 + md;
            if (den == 0)
                r.fault = 1'b1;
            else
            begin
                x2 = div_trunc(mc * 32'd2048, den);
                b5 = x1 + x2;
                stored_b5 = b5;
                r.result_value = asr32(b5 + 32'd8, 4);
            end
        end
        else
        begin
            up = {8'd0, req.raw_value} >> (8 - cal_oss);
            b6 = stored_b5 - 32'd4000;
            sq = asr32(b6 * b6, 12);
            x1 = asr32(b2 * sq, 11);
            x2 = asr32(ac2 * b6, 11);
            x3 = x1 + x2;
            b3 = div_trunc(((ac1 * 32'd4 + x3) << cal_oss) + 32'd2, 32'd4);
            x1 = asr32(ac3 * b6, 13);
            x2 = asr32(b1 * sq, 16);
            x3 = asr32(x1 + x2 + 32'd2, 2);
            b4 = (ac4 * (x3 + 32'd32768)) >> 15;
            b7 = (up - b3) * (32'd50000 >> cal_oss);
            if (b4 == 0)
                r.fault = 1'b1;
            else
            begin
                if (!b7[31])
                    p = (b7 * 32'd2) / b4;
                else
                    p = (b7 / b4) * 32'd2;
                x1 = asr32(p, 8);
                x1 = x1 * x1;
                x1 = asr32(x1 * 32'd3038, 16);
                x2 = asr32(-32'd7357 * p, 16);
                r.result_value = p + asr32(x1 + x2 + 32'd3791, 4);
            end
        end
        return r;
    endfunction

    // Write one register; the caller drops cfg_we after the last write.
    task automatic write_reg(input logic [CFG_INDEX_WIDTH-1:0] idx, input logic [47:0] val);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        case (idx)
            REG_ABC:  cal_abc = val;
            REG_456:  cal_456 = val;
            REG_B12:  cal_b12 = val[31:0];
            REG_MCMD: cal_mcmd = val[31:0];
            REG_OSS:  cal_oss = val[1:0];
            default:  ;
        endcase
    endtask

    // Drop valid, hold until every result is back, then let the block settle.
    task automatic wait_idle();
        in_valid <= 1'b0;
        while (compensated_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic load_cal(input logic [47:0] abc, input logic [47:0] c456,
                            input logic [31:0] b12, input logic [31:0] mcmd,
                            input logic [1:0] oss);
        wait_idle();
        write_reg(REG_ABC, abc);
        write_reg(REG_456, c456);
        write_reg(REG_B12, {16'd0, b12});
        write_reg(REG_MCMD, {16'd0, mcmd});
        write_reg(REG_OSS, {46'd0, oss});
        cfg_we <= 1'b0;
    endtask

    // Send one request; predict at acceptance. Idle gaps before the request.
    // Valid stays high after acceptance until the next request or a drain.
    task automatic send(input logic mode, input logic [23:0] raw);
        bsc_in_t req;
        while (!steady && $urandom_range(99) < 10)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        req.mode = mode;
        req.raw_value = raw;
        in_valid <= 1'b1;
        in_data <= req;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        compensated_q.push_back(compensate(req));
    endtask

    // Receiver stall pattern.
    always @(posedge clk)
    begin
        if (!rst_n)
            out_stall <= 1'b0;
        else
            out_stall <= !steady && ($urandom_range(99) < 10);
    end

    // Compare each accepted result with the oldest expectation.
    always @(posedge clk)
    begin
        bsc_out_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (compensated_q.size() == 0)
            begin
                $display("%0t: unexpected result kind=%0d value=%0d fault=%0d", $time,
                         out_data.result_kind, out_data.result_value, out_data.fault);
                fail_count++;
            end
            else
            begin
                want = compensated_q.pop_front();
                if (out_data.result_kind !== want.result_kind)
                begin
                    $display("%0t: result_kind expected %0d actual %0d", $time,
                             want.result_kind, out_data.result_kind);
                    fail_count++;
                end
                if (out_data.result_value !== want.result_value)
                begin
                    $display("%0t: result_value expected %0d actual %0d", $time,
                             want.result_value, out_data.result_value);
                    fail_count++;
                end
                if (out_data.fault !== want.fault)
                begin
                    $display("%0t: fault expected %0d actual %0d", $time,
                             want.fault, out_data.fault);
                    fail_count++;
                end
            end
        end
    end

    // Datasheet example calibration.
    localparam logic [47:0] DS_ABC  = {16'd408, 16'hFFB8, 16'hC7D1};
    localparam logic [47:0] DS_456  = {16'd32741, 16'd32757, 16'd23153};
    localparam logic [31:0] DS_B12  = {16'd6190, 16'd4};
    localparam logic [31:0] DS_MCMD = {16'hDDF9, 16'd2868};

    stim_row_t rows[$];

    function automatic stim_row_t mk(input logic cs, input logic [47:0] abc,
                                     input logic [47:0] c456, input logic [31:0] b12,
                                     input logic [31:0] mcmd, input logic [1:0] oss,
                                     input logic mode, input logic [23:0] raw,
                                     input logic known, input logic [31:0] kv,
                                     input logic kf);
        stim_row_t r;
        r.cfg_set = cs; r.abc = abc; r.c456 = c456; r.b12 = b12; r.mcmd = mcmd;
        r.oss = oss; r.mode = mode; r.raw = raw; r.known = known;
        r.known_value = kv; r.known_fault = kf;
        return r;
    endfunction

    initial
    begin
        #20_000_000;
        $display("barometric_sensor_compensation test failed");
        $finish;
    end

    initial
    begin
        bsc_out_t want;
        logic [1:0] oss_pick;
        int n;
        rst_n = 1'b0;
        in_valid = 1'b0;
        in_data = '0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        cal_abc = '0; cal_456 = '0; cal_b12 = '0; cal_mcmd = '0; cal_oss = '0;
        stored_b5 = '0;
        fail_count = 0;
        steady = 1'b0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // After reset every coefficient is zero: the temperature divisor is zero,
        // and so is B4 for a pressure request issued before any temperature.
        rows.push_back(mk(0, 0, 0, 0, 0, 0, 1'b1, 24'h000000, 1, 32'd0, 1));
        rows.push_back(mk(0, 0, 0, 0, 0, 0, 1'b0, 24'hFFFFFF, 1, 32'd0, 1));
        // Datasheet example: UT 27898 gives 150, UP 23843 (oss 0) gives 69964.
        rows.push_back(mk(1, DS_ABC, DS_456, DS_B12, DS_MCMD, 0,
                          1'b0, 24'h006CFA, 1, 32'd150, 0));
        rows.push_back(mk(0, 0, 0, 0, 0, 0, 1'b1, 24'h5D2300, 1, 32'd69964, 0));
        // Upper bits of a temperature reading are ignored.
        rows.push_back(mk(0, 0, 0, 0, 0, 0, 1'b0, 24'hFF6CFA, 1, 32'd150, 0));
        rows.push_back(mk(0, 0, 0, 0, 0, 0, 1'b0, 24'h000000, 0, 0, 0));
        rows.push_back(mk(0, 0, 0, 0, 0, 0, 1'b0, 24'h00FFFF, 0, 0, 0));
        rows.push_back(mk(0, 0, 0, 0, 0, 0, 1'b1, 24'hFFFFFF, 0, 0, 0));
        rows.push_back(mk(0, 0, 0, 0, 0, 0, 1'b1, 24'h000000, 0, 0, 0));
        // Oversampling extremes.
        rows.push_back(mk(1, DS_ABC, DS_456, DS_B12, DS_MCMD, 3,
                          1'b1, 24'hABCDEF, 0, 0, 0));
        rows.push_back(mk(0, 0, 0, 0, 0, 0, 1'b1, 24'hFFFFFF, 0, 0, 0));
        // Temperature divisor zero: MD = 0 and AC5 = 0 make X1 + MD zero;
        // stored B5 is kept for the following pressure request.
        rows.push_back(mk(1, DS_ABC, {16'd32741, 16'd0, 16'd23153}, DS_B12, 32'hDDF90000, 1,
                          1'b0, 24'h001234, 1, 32'd0, 1));
        rows.push_back(mk(0, 0, 0, 0, 0, 0, 1'b1, 24'h5D2300, 0, 0, 0));
        // Pressure divisor zero: AC4 = 0.
        rows.push_back(mk(1, DS_ABC, {16'd0, 16'd32757, 16'd23153}, DS_B12, DS_MCMD, 2,
                          1'b1, 24'h5D2300, 1, 32'd0, 1));
        // All-ones coefficients: every sign and every wrap.
        rows.push_back(mk(1, 48'hFFFFFFFFFFFF, 48'hFFFFFFFFFFFF, 32'hFFFFFFFF,
                          32'hFFFFFFFF, 3, 1'b0, 24'h00FFFF, 0, 0, 0));
        rows.push_back(mk(0, 0, 0, 0, 0, 0, 1'b1, 24'hFFFFFF, 0, 0, 0));
        rows.push_back(mk(0, 0, 0, 0, 0, 0, 1'b0, 24'h000000, 0, 0, 0));
        rows.push_back(mk(0, 0, 0, 0, 0, 0, 1'b1, 24'h000001, 0, 0, 0));
        // Most negative coefficients.
        rows.push_back(mk(1, 48'h800080008000, 48'h000080000001, 32'h80008000,
                          32'h80000001, 0, 1'b0, 24'h000001, 0, 0, 0));
        rows.push_back(mk(0, 0, 0, 0, 0, 0, 1'b1, 24'h800000, 0, 0, 0));

        foreach (rows[i])
        begin
            if (rows[i].cfg_set)
                load_cal(rows[i].abc, rows[i].c456, rows[i].b12, rows[i].mcmd, rows[i].oss);
            send(rows[i].mode, rows[i].raw);
            if (rows[i].known)
            begin
                want = compensated_q[$];
                if (want.result_value !== rows[i].known_value
                    || want.fault !== rows[i].known_fault)
                begin
                    $display("%0t: row %0d expected value=%0d fault=%0d actual %0d/%0d",
                             $time, i, rows[i].known_value, rows[i].known_fault,
                             want.result_value, want.fault);
                    fail_count++;
                end
            end
        end

        // Random phases: mostly realistic calibration near the datasheet set,
        // sometimes fully random words. Temperature then pressure pairs dominate.
        n = 0;
        while (n < RAND_REQUESTS)
        begin
            oss_pick = 2'($urandom_range(3));
            if ($urandom_range(3) == 0)
                load_cal(48'({$urandom, $urandom}), 48'({$urandom, $urandom}),
                         $urandom, $urandom, oss_pick);
            else
                load_cal({DS_ABC[47:32] + 16'($urandom_range(400)), 16'($urandom),
                          DS_ABC[15:0] + 16'($urandom_range(2000))},
                         {16'($urandom_range(65535, 20000)), 16'($urandom_range(65535, 16000)),
                          16'($urandom)},
                         {16'($urandom), 16'($urandom)},
                         {16'($urandom), 16'($urandom_range(6000))},
                         oss_pick);
            steady = ($urandom_range(5) == 0);
            repeat (60)
            begin
                if ($urandom_range(9) < 7)
                begin
                    send(1'b0, 24'($urandom));
                    send(1'b1, {16'($urandom_range(16'hFFFF, 16'h4000)), 8'($urandom)});
                    n += 2;
                end
                else
                begin
                    send(1'($urandom_range(1)), 24'($urandom));
                    n++;
                end
            end
            steady = 1'b0;
        end

        fork
            begin
                wait_idle();
            end
        join
        if (fail_count == 0)
            $display("barometric_sensor_compensation test passed");
        else
            $display("barometric_sensor_compensation test failed");
        $finish;
    end

endmodule
